>>> rtl/core/dwc_pkg.sv
// Shared types and constants for the depthwise convolution block.
package dwc_pkg;

  localparam int DEF_MAX_ROWS     = 64;
  localparam int DEF_MAX_COLS     = 64;
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int DEF_MAX_MULT     = 4;
  localparam int DEF_KERNEL_H     = 3;
  localparam int DEF_KERNEL_W     = 3;

  // Signed image coordinate width, wide enough for row*step + tap*spread.
  localparam int COORD_W = 13;
  localparam int SUM_W   = 35;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 7;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] CMD_WEIGHT  = 2'd0;
  localparam logic [1:0] CMD_SAMPLE  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 3'd0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_STEP_ROWS    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_STEP_COLS    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SPREAD_ROWS  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SPREAD_COLS  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_PAD_TOP      = 3'd6;
  localparam logic [CFG_AW-1:0] REG_PAD_LEFT     = 3'd7;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [3:0]         chan;
    logic [1:0]         mult;
    logic [1:0]         tap_row;
    logic [1:0]         tap_col;
    logic signed [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] conv_sum;
    logic                    status;
  } out_item_t;

  // Effective configuration: sizes clamped, zero steps and spreads taken as one.
  typedef struct packed {
    logic [6:0] height;
    logic [6:0] width;
    logic [3:0] step_r;
    logic [3:0] step_c;
    logic [3:0] spread_r;
    logic [3:0] spread_c;
    logic [4:0] pad_top;
    logic [4:0] pad_left;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_WR_WEIGHT = 2'd0,
    OP_WR_SAMPLE = 2'd1,
    OP_COMPUTE   = 2'd2,
    OP_REJECT    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [3:0]         chan;
    logic [1:0]         mult;
    logic [1:0]         tap_row;
    logic [1:0]         tap_col;
    logic signed [15:0] sample;
    logic [COORD_W-1:0] base_r;
    logic [COORD_W-1:0] base_c;
  } entry_t;

endpackage

>>> rtl/core/dwc_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
interface dwc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/dwc_front.sv
// Front end: accepts items, drops ignored ones and classifies the rest.
module dwc_front
  import dwc_pkg::*;
#(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_MULT     = DEF_MAX_MULT,
  parameter int KERNEL_H     = DEF_KERNEL_H,
  parameter int KERNEL_W     = DEF_KERNEL_W
) (
  dwc_stream_if.sink in_ch,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  in_item_t    it;
  logic [10:0] span_r;
  logic [10:0] span_c;
  logic        keep;
  logic        bad;

  assign it = in_ch.data;
  assign in_ch.ready = !q_full;

  always_comb begin
    span_r = 11'(it.row) * 11'(cfg.step_r);
    span_c = 11'(it.col) * 11'(cfg.step_c);
    // row < ceil(h/step) is the same as row*step < h.
    bad = (span_r >= 11'(cfg.height)) || (span_c >= 11'(cfg.width)) ||
          (int'(it.chan) >= MAX_CHANNELS) || (int'(it.mult) >= MAX_MULT);

    push_entry.row     = it.row;
    push_entry.col     = it.col;
    push_entry.chan    = it.chan;
    push_entry.mult    = it.mult;
    push_entry.tap_row = it.tap_row;
    push_entry.tap_col = it.tap_col;
    push_entry.sample  = it.sample;
    push_entry.base_r  = COORD_W'(span_r) - COORD_W'(cfg.pad_top);
    push_entry.base_c  = COORD_W'(span_c) - COORD_W'(cfg.pad_left);
    push_entry.op      = OP_REJECT;
    keep = 1'b0;
    case (it.command)
      CMD_WEIGHT: begin
        push_entry.op = OP_WR_WEIGHT;
        keep = (int'(it.tap_row) < KERNEL_H) && (int'(it.tap_col) < KERNEL_W) &&
               (int'(it.chan) < MAX_CHANNELS) && (int'(it.mult) < MAX_MULT);
      end
      CMD_SAMPLE: begin
        push_entry.op = OP_WR_SAMPLE;
        keep = (int'(it.row) < MAX_ROWS) && (int'(it.col) < MAX_COLS) &&
               (int'(it.chan) < MAX_CHANNELS);
      end
      CMD_COMPUTE: begin
        push_entry.op = bad ? OP_REJECT : OP_COMPUTE;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
    push = in_ch.valid && !q_full && keep;
  end

endmodule

>>> rtl/core/dwc_queue.sv
// Short queue of classified operations between front and back ends.
module dwc_queue
  import dwc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  entry_t      slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full      = (count == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/core/dwc_back.sv
// Back end: owns the image and weight memories and walks the kernel taps.
module dwc_back
  import dwc_pkg::*;
#(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_MULT     = DEF_MAX_MULT,
  parameter int KERNEL_H     = DEF_KERNEL_H,
  parameter int KERNEL_W     = DEF_KERNEL_W
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_not_empty,
  input  entry_t head,
  output logic pop,
  dwc_stream_if.source out_ch
);

  localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS * MAX_CHANNELS;
  localparam int WGT_DEPTH = KERNEL_H * KERNEL_W * MAX_CHANNELS * MAX_MULT;
  localparam int IMG_AW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int WGT_AW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int KH_W = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
  localparam int KW_W = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;

  typedef enum logic [1:0] {IDLE, RUN, DRAIN, DONE} state_t;

  logic signed [15:0] img_mem [IMG_DEPTH];
  logic signed [15:0] wgt_mem [WGT_DEPTH];

  state_t             state;
  entry_t             cur;
  logic [KH_W-1:0]    kh;
  logic [KW_W-1:0]    kw;
  logic [COORD_W-1:0] r_cur;
  logic [COORD_W-1:0] c_cur;
  logic               last_tap;
  logic               in_image;
  logic [IMG_AW-1:0]  img_ra;
  logic [WGT_AW-1:0]  wgt_ra;
  logic [IMG_AW-1:0]  img_wa;
  logic [WGT_AW-1:0]  wgt_wa;
  logic               img_we;
  logic               wgt_we;
  logic signed [15:0] img_q;
  logic signed [15:0] wgt_q;
  logic               rd_v;
  logic               rd_ok;
  logic               rd_last;
  logic signed [31:0] prod;
  logic               mul_v;
  logic               mul_last;
  logic signed [SUM_W-1:0] acc;
  logic               bad;
  logic               res_valid;
  out_item_t          res;

  assign pop = (state == IDLE) && q_not_empty;
  assign out_ch.valid = res_valid;
  assign out_ch.data  = res;

  always_comb begin
    last_tap = (int'(kh) == KERNEL_H - 1) && (int'(kw) == KERNEL_W - 1);
    in_image = !r_cur[COORD_W-1] && (r_cur < COORD_W'(cfg.height)) &&
               !c_cur[COORD_W-1] && (c_cur < COORD_W'(cfg.width));
    img_ra = IMG_AW'((int'(r_cur) * MAX_COLS + int'(c_cur)) * MAX_CHANNELS + int'(cur.chan));
    wgt_ra = WGT_AW'(((int'(kh) * KERNEL_W + int'(kw)) * MAX_CHANNELS + int'(cur.chan))
                     * MAX_MULT + int'(cur.mult));
    img_wa = IMG_AW'((int'(head.row) * MAX_COLS + int'(head.col)) * MAX_CHANNELS
                     + int'(head.chan));
    wgt_wa = WGT_AW'(((int'(head.tap_row) * KERNEL_W + int'(head.tap_col)) * MAX_CHANNELS
                      + int'(head.chan)) * MAX_MULT + int'(head.mult));
    img_we = pop && (head.op == OP_WR_SAMPLE);
    wgt_we = pop && (head.op == OP_WR_WEIGHT);
  end

  always_ff @(posedge clk) begin
    if (img_we) img_mem[img_wa] <= head.sample;
    img_q <= img_mem[img_ra];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) wgt_mem[wgt_wa] <= head.sample;
    wgt_q <= wgt_mem[wgt_ra];
  end

  // Product stage; taps outside the image contribute zero.
  always_ff @(posedge clk) begin
    prod <= rd_ok ? img_q * wgt_q : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rd_v      <= 1'b0;
      rd_last   <= 1'b0;
      mul_v     <= 1'b0;
      mul_last  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_v     <= (state == RUN);
      rd_ok    <= (state == RUN) && in_image;
      rd_last  <= (state == RUN) && last_tap;
      mul_v    <= rd_v;
      mul_last <= rd_last;
      if (mul_v) acc <= acc + SUM_W'(prod);
      if (out_ch.valid && out_ch.ready && (state != DONE)) res_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (pop && (head.op == OP_COMPUTE || head.op == OP_REJECT)) begin
            cur   <= head;
            kh    <= '0;
            kw    <= '0;
            r_cur <= head.base_r;
            c_cur <= head.base_c;
            acc   <= '0;
            bad   <= (head.op == OP_REJECT);
            state <= (head.op == OP_REJECT) ? DONE : RUN;
          end
        end
        RUN: begin
          if (int'(kw) == KERNEL_W - 1) begin
            kw    <= '0;
            kh    <= kh + 1'b1;
            c_cur <= cur.base_c;
            r_cur <= r_cur + COORD_W'(cfg.spread_r);
          end else begin
            kw    <= kw + 1'b1;
            c_cur <= c_cur + COORD_W'(cfg.spread_c);
          end
          if (last_tap) state <= DRAIN;
        end
        DRAIN: begin
          if (mul_last) state <= DONE;
        end
        DONE: begin
          if (!res_valid || out_ch.ready) begin
            res.conv_sum <= bad ? '0 : acc;
            res.status   <= bad;
            res_valid    <= 1'b1;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/depthwise_conv2d_forward.sv
// Depthwise 2D convolution with stride, dilation and zero padding.
// Load items (weights, image samples) are written to memory as the idle back
// end pops them. For a compute item the back end reads one tap per cycle from
// its image and weight memories, then a read, a multiply and an accumulate
// stage drain before the result is registered. A request outside the output
// size skips the taps and is answered with status 1. A four-entry queue
// between front and back lets input items be taken while the back end
// computes or a result waits to be taken.
// Memories have no reset; read only entries that were loaded.
module depthwise_conv2d_forward
  import dwc_pkg::*;
#(
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_MULT     = DEF_MAX_MULT,
  parameter int KERNEL_H     = DEF_KERNEL_H,
  parameter int KERNEL_W     = DEF_KERNEL_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  dwc_stream_if.sink        in_ch,
  dwc_stream_if.source      out_ch
);

  logic [6:0] image_height;
  logic [6:0] image_width;
  logic [3:0] step_rows;
  logic [3:0] step_cols;
  logic [3:0] spread_rows;
  logic [3:0] spread_cols;
  logic [4:0] pad_top;
  logic [4:0] pad_left;
  cfg_t       cfg;
  logic       push;
  entry_t     push_entry;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;
  entry_t     head;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= 7'd64;
      image_width  <= 7'd64;
      step_rows    <= 4'd1;
      step_cols    <= 4'd1;
      spread_rows  <= 4'd1;
      spread_cols  <= 4'd1;
      pad_top      <= 5'd0;
      pad_left     <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        REG_STEP_ROWS:    step_rows    <= cfg_wdata[3:0];
        REG_STEP_COLS:    step_cols    <= cfg_wdata[3:0];
        REG_SPREAD_ROWS:  spread_rows  <= cfg_wdata[3:0];
        REG_SPREAD_COLS:  spread_cols  <= cfg_wdata[3:0];
        REG_PAD_TOP:      pad_top      <= cfg_wdata[4:0];
        REG_PAD_LEFT:     pad_left     <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_height == '0) cfg.height = 7'd1;
    else if (int'(image_height) > MAX_ROWS) cfg.height = 7'(MAX_ROWS);
    else cfg.height = image_height;
    if (image_width == '0) cfg.width = 7'd1;
    else if (int'(image_width) > MAX_COLS) cfg.width = 7'(MAX_COLS);
    else cfg.width = image_width;
    cfg.step_r   = (step_rows == '0) ? 4'd1 : step_rows;
    cfg.step_c   = (step_cols == '0) ? 4'd1 : step_cols;
    cfg.spread_r = (spread_rows == '0) ? 4'd1 : spread_rows;
    cfg.spread_c = (spread_cols == '0) ? 4'd1 : spread_cols;
    cfg.pad_top  = pad_top;
    cfg.pad_left = pad_left;
  end

  dwc_front #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_MULT(MAX_MULT), .KERNEL_H(KERNEL_H), .KERNEL_W(KERNEL_W)
  ) u_front (
    .in_ch(in_ch), .cfg(cfg), .q_full(q_full), .push(push), .push_entry(push_entry)
  );

  dwc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_entry(push_entry), .pop(pop),
    .full(q_full), .not_empty(q_not_empty), .head(head)
  );

  dwc_back #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_MULT(MAX_MULT), .KERNEL_H(KERNEL_H), .KERNEL_W(KERNEL_W)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_not_empty(q_not_empty), .head(head),
    .pop(pop), .out_ch(out_ch)
  );

endmodule
